### hdl/assert_macros.svh
// Assertion helpers included by button_gesture_classifier.sv.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// Types and constants of the button gesture classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bgc_pkg;

    localparam int TICK_W     = 16;
    localparam int DEBOUNCE_W = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [TICK_W-1:0] tick_t;

    typedef enum logic [1:0] {
        GESTURE_NONE   = 2'd0,
        GESTURE_TAP    = 2'd1,
        GESTURE_DOUBLE = 2'd2,
        GESTURE_HOLD   = 2'd3
    } gesture_t;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_TAP = 2'd2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET   = 10'd40;
    localparam tick_t                 HOLD_RESET       = 16'd3000;
    localparam tick_t                 DOUBLE_TAP_RESET = 16'd400;

    // Counter step that sticks at full scale.
    function automatic tick_t sat_inc(input tick_t v);
        sat_inc = (v == '1) ? v : v + tick_t'(1);
    endfunction

endpackage

`default_nettype wire

### hdl/button_gesture_classifier.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Classifies one push button into tap, double tap and hold, one tick a beat.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat is one millisecond tick carrying the button level and the
//   immediate-tap flag. Every input beat produces exactly one output beat with
//   a gesture code: none, tap, double tap or hold.
//   The configuration channel writes debounce_ticks (index 0), hold_ticks
//   (index 1) and double_tap_ticks (index 2); other indexes are dropped. It is
//   always ready and should only be written while no tick is in flight.
// Pipeline and throughput:
//   The whole classification is one pass of counters and compares between the
//   input port and the result register, so a result appears in the cycle after
//   its tick is accepted, and one tick is taken each cycle out_ready is high.
// Stalls:
//   The block takes a new tick whenever the result register is empty or is
//   being drained in the same cycle. If the receiver holds ready low, the
//   result waits in place and in_ready drops until it is taken.
// Reset:
//   rst_n clears all tracking state and the result valid flag, and restores the
//   registers to 40, 3000 and 400 ticks.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module button_gesture_classifier
    import bgc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Tick input channel.
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  button_down,
    input  wire logic                  immediate_tap,
    // Gesture output channel.
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 gesture
);

    // Configuration registers.
    logic [DEBOUNCE_W-1:0] debounce_reg;
    tick_t                 hold_reg;
    tick_t                 double_tap_reg;

    // Tracking state.
    logic  pressed_reg,       pressed_next;
    tick_t press_ticks_reg,   press_ticks_next;
    logic  hold_reported_reg, hold_reported_next;
    logic  tap_pending_reg,   tap_pending_next;
    tick_t since_tap_reg,     since_tap_next;

    // Result register.
    logic     out_valid_reg;
    gesture_t gesture_reg, gesture_next;

    logic  in_fire;
    logic  skip_check;
    tick_t press_inc;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign gesture   = gesture_reg;

    assign press_inc = sat_inc(press_ticks_reg);

    // One tick of the classifier. The window counter advances first, the button
    // edge next, then an expired window reports its tap unless skip_check is set.
    always_comb
    begin
        pressed_next       = pressed_reg;
        press_ticks_next   = press_ticks_reg;
        hold_reported_next = hold_reported_reg;
        tap_pending_next   = tap_pending_reg;
        since_tap_next     = tap_pending_reg ? sat_inc(since_tap_reg) : since_tap_reg;
        gesture_next       = GESTURE_NONE;
        skip_check         = 1'b0;

        if (button_down && !pressed_reg)
        begin
            pressed_next       = 1'b1;
            press_ticks_next   = '0;
            hold_reported_next = 1'b0;
        end
        else if (button_down)
        begin
            press_ticks_next = press_inc;
            if (!hold_reported_reg && press_inc > hold_reg)
            begin
                hold_reported_next = 1'b1;
                tap_pending_next   = 1'b0;
                gesture_next       = GESTURE_HOLD;
            end
        end
        else if (pressed_reg)
        begin
            press_ticks_next = press_inc;
            pressed_next     = 1'b0;
            if (hold_reported_reg || press_inc <= tick_t'(debounce_reg))
            begin
                skip_check = 1'b1;
            end
            else if (immediate_tap)
            begin
                gesture_next = GESTURE_TAP;
                skip_check   = 1'b1;
            end
            else if (tap_pending_reg && since_tap_next < double_tap_reg)
            begin
                tap_pending_next = 1'b0;
                gesture_next     = GESTURE_DOUBLE;
            end
            else
            begin
                tap_pending_next = 1'b1;
                since_tap_next   = '0;
            end
        end

        if (!skip_check && tap_pending_next && since_tap_next >= double_tap_reg)
        begin
            tap_pending_next = 1'b0;
            gesture_next     = GESTURE_TAP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            hold_reg       <= HOLD_RESET;
            double_tap_reg <= DOUBLE_TAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEBOUNCE:   debounce_reg   <= cfg_data[DEBOUNCE_W-1:0];
                REG_HOLD:       hold_reg       <= cfg_data;
                REG_DOUBLE_TAP: double_tap_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg       <= 1'b0;
            press_ticks_reg   <= '0;
            hold_reported_reg <= 1'b0;
            tap_pending_reg   <= 1'b0;
            since_tap_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                pressed_reg       <= pressed_next;
                press_ticks_reg   <= press_ticks_next;
                hold_reported_reg <= hold_reported_next;
                tap_pending_reg   <= tap_pending_next;
                since_tap_reg     <= since_tap_next;
                out_valid_reg     <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The gesture is payload and carries no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            gesture_reg <= gesture_next;
        end
    end

    // A reported hold marks the press and drops any waiting tap.
    `ASSERT_NEXT(a_hold_marks, in_fire && gesture_next == GESTURE_HOLD,
                 hold_reported_reg && !tap_pending_reg)
    // A double tap consumes the waiting tap.
    `ASSERT_NEXT(a_double_clears, in_fire && gesture_next == GESTURE_DOUBLE,
                 !tap_pending_reg && gesture_reg == GESTURE_DOUBLE)
    // The input side stalls only behind a result that the receiver refuses.
    `ASSERT_SAME(a_stall_cause, !in_ready, out_valid_reg && !out_ready)

endmodule

`default_nettype wire

### sim/button_gesture_classifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_classifier_test
// Self-checking bench for the tap, double tap and hold classifier.
// ----------------------------------------------------------------------------
// A scoreboard object tracks press and tap-window state the same way the block
// should and queues one expected gesture per accepted tick. Ticks come first
// from short hand-written sequences at the reset thresholds and around every
// threshold of a tight setting, then from random press and release patterns
// under several register settings with small limits, so that holds, windows
// and debounce edges all come up within a short run.
// Both handshake sides stall at random, and one phase runs with no stalls.
// ----------------------------------------------------------------------------

import bgc_pkg::*;

// Holds the predicted classifier state and the gestures still owed by the DUT.
class gesture_scoreboard;
    logic [DEBOUNCE_W-1:0] debounce_lim;
    tick_t                 hold_lim;
    tick_t                 window_lim;

    bit    pressed;
    bit    hold_seen;
    bit    tap_pending;
    tick_t press_len;
    tick_t since_tap;

    gesture_t expected_q[$];
    int       errors;
    int       ticks;
    int       settings;
    int       seen[4];

    function new();
        debounce_lim = DEBOUNCE_RESET;
        hold_lim     = HOLD_RESET;
        window_lim   = DOUBLE_TAP_RESET;
        pressed      = 1'b0;
        hold_seen    = 1'b0;
        tap_pending  = 1'b0;
        press_len    = '0;
        since_tap    = '0;
        errors       = 0;
        ticks        = 0;
        settings     = 1;
        seen         = '{0, 0, 0, 0};
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_DEBOUNCE:   debounce_lim = data[DEBOUNCE_W-1:0];
            REG_HOLD:       hold_lim     = data;
            REG_DOUBLE_TAP: window_lim   = data;
            default:        ;
        endcase
    endfunction

    // Timers stick at full scale instead of wrapping.
    function tick_t bump(input tick_t v);
        return (v == '1) ? v : v + tick_t'(1);
    endfunction

    // Advances the predicted state by one accepted tick and queues its gesture.
    function void note_tick(input bit down, input bit imm);
        gesture_t g;
        bit       skip_window;
        g           = GESTURE_NONE;
        skip_window = 1'b0;
        ticks++;

        if (tap_pending)
            since_tap = bump(since_tap);

        if (down && !pressed) begin
            pressed   = 1'b1;
            press_len = '0;
            hold_seen = 1'b0;
        end else if (down) begin
            press_len = bump(press_len);
            if (!hold_seen && press_len > hold_lim) begin
                hold_seen   = 1'b1;
                tap_pending = 1'b0;
                g           = GESTURE_HOLD;
            end
        end else if (pressed) begin
            press_len = bump(press_len);
            pressed   = 1'b0;
            if (hold_seen || press_len <= tick_t'(debounce_lim)) begin
                skip_window = 1'b1;
            end else if (imm) begin
                g           = GESTURE_TAP;
                skip_window = 1'b1;
            end else if (tap_pending && since_tap < window_lim) begin
                tap_pending = 1'b0;
                g           = GESTURE_DOUBLE;
            end else begin
                tap_pending = 1'b1;
                since_tap   = '0;
            end
        end

        if (!skip_window && tap_pending && since_tap >= window_lim) begin
            tap_pending = 1'b0;
            g           = GESTURE_TAP;
        end

        expected_q.push_back(g);
    endfunction

    function void check_gesture(input gesture_t got);
        gesture_t want;
        if (expected_q.size() == 0) begin
            errors++;
            $display("%0t ns: gesture beat %0d with no tick waiting for it", $time, got);
            return;
        end
        want = expected_q.pop_front();
        if (got !== want) begin
            errors++;
            $display("%0t ns: gesture mismatch, expected %0d actual %0d", $time, want, got);
        end else begin
            seen[int'(want)]++;
        end
    endfunction
endclass

module button_gesture_classifier_test;

    // Index 3 decodes to no register; one write to it checks that it is dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  button_down;
    logic                  immediate_tap;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            gesture;

    // When set, neither side stalls.
    bit calm;

    gesture_scoreboard sb;

    button_gesture_classifier i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .button_down   (button_down),
        .immediate_tap (immediate_tap),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .gesture       (gesture)
    );

    always #1 clk = ~clk;

    // The receiver drops ready in roughly a quarter of the cycles.
    always @(negedge clk)
        out_ready <= calm || ($urandom_range(99) >= 23);

    // Every gesture beat taken at a rising edge is checked against the oldest
    // expectation. Signals are read before the edge's own updates land.
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_gesture(gesture_t'(gesture));

    // Sends one tick beat. Called at a falling edge, returns at a falling edge.
    // While idling, the payload carries junk so that only valid beats matter.
    task automatic send_tick(input bit down, input bit imm);
        while (!calm && $urandom_range(99) < 23) begin
            in_valid      <= 1'b0;
            button_down   <= 1'($urandom_range(1));
            immediate_tap <= 1'($urandom_range(1));
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        button_down   <= down;
        immediate_tap <= imm;
        do @(posedge clk); while (!in_ready);
        sb.note_tick(down, imm);
        @(negedge clk);
    endtask

    // Holds the button for len ticks, then releases it with the given mode flag.
    // The flag only matters on the release tick, so it is random elsewhere.
    task automatic press_release(input int len, input bit imm);
        repeat (len) send_tick(1'b1, 1'($urandom_range(1)));
        send_tick(1'b0, imm);
    endtask

    task automatic idle_ticks(input int n);
        repeat (n) send_tick(1'b0, 1'($urandom_range(1)));
    endtask

    // Lets the block run dry so that registers can be written safely.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Writes one register and leaves valid high for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] deb,
                             input logic [CFG_DATA_W-1:0] hold,
                             input logic [CFG_DATA_W-1:0] win,
                             input bit poke_unused);
        drain();
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_HOLD, hold);
        write_reg(REG_DOUBLE_TAP, win);
        if (poke_unused)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        sb.settings++;
    endtask

    // Random press and release patterns scaled to the current thresholds.
    // Press lengths cluster around the debounce and hold limits, and release
    // gaps around the double-tap window, so the boundaries get hit often.
    // A tenth of the traffic is plain noise on the button line.
    task automatic gesture_mix(input int budget);
        int deb;
        int hold;
        int win;
        int len;
        int gap;
        int roll;
        int start;
        deb   = int'(sb.debounce_lim);
        hold  = int'(sb.hold_lim);
        win   = int'(sb.window_lim);
        start = sb.ticks;
        while (sb.ticks - start < budget) begin
            roll = int'($urandom_range(99));
            if (roll < 10) begin
                repeat ($urandom_range(6, 1))
                    send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
                roll = int'($urandom_range(99));
                if (roll < 35)
                    len = deb + int'($urandom_range(3, 1));
                else if (roll < 50)
                    len = deb - 1 + int'($urandom_range(1));
                else if (roll < 70)
                    len = hold + int'($urandom_range(3));
                else
                    len = int'($urandom_range(hold + 3, 1));
                if (len < 1)
                    len = 1;
                press_release(len, $urandom_range(99) < 25);

                roll = int'($urandom_range(99));
                if (roll < 60)
                    gap = int'($urandom_range(win + 3));
                else if (roll < 85)
                    gap = win + int'($urandom_range(4)) - 2;
                else
                    gap = int'($urandom_range(2));
                if (gap < 0)
                    gap = 0;
                idle_ticks(gap);
            end
        end
    endtask

    initial begin
        sb            = new();
        calm          = 1'b0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        button_down   = 1'b0;
        immediate_tap = 1'b0;
        out_ready     = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset thresholds, untouched: a lone tap that waits out the window,
        // a double tap and an immediate tap.
        press_release(45, 1'b0);
        idle_ticks(405);
        press_release(45, 1'b0);
        idle_ticks(20);
        press_release(45, 1'b0);
        press_release(45, 1'b1);
        idle_ticks(3);

        // Tight thresholds, hand-picked: a release exactly at the debounce limit
        // is ignored, one tick more with the mode flag taps at once, a second
        // release just as the window closes reopens it, then the window runs
        // out, and a long press gives a single hold.
        configure(16'd2, 16'd6, 16'd4, 1'b0);
        press_release(2, 1'b0);
        press_release(3, 1'b1);
        press_release(3, 1'b0);
        press_release(3, 1'b0);
        idle_ticks(5);
        press_release(8, 1'b0);
        press_release(7, 1'b0);
        idle_ticks(5);

        // Random patterns under a spread of settings, including a hold limit of
        // one, a zero debounce and a zero-length window. The debounce value with
        // junk in its upper bits checks that only 10 bits are kept.
        configure(16'd2, 16'd6, 16'd4, 1'b1);
        gesture_mix(120);
        configure(16'd0, 16'd1, 16'd1, 1'b0);
        gesture_mix(120);
        configure(16'd0, 16'd8, 16'd0, 1'b0);
        gesture_mix(120);
        configure(16'hFC05, 16'd20, 16'd12, 1'b0);
        gesture_mix(120);
        calm = 1'b1;
        configure(16'd1, 16'd3, 16'd30, 1'b0);
        gesture_mix(250);
        calm = 1'b0;
        configure(16'd7, 16'd40, 16'd6, 1'b0);
        gesture_mix(120);
        configure(16'($urandom_range(6)), 16'($urandom_range(30, 8)),
                  16'($urandom_range(20, 1)), 1'b0);
        gesture_mix(120);

        drain();
        $display("Sent %0d ticks under %0d register settings.", sb.ticks, sb.settings);
        $display("Matched %0d taps, %0d double taps, %0d holds and %0d quiet ticks.",
                 sb.seen[GESTURE_TAP], sb.seen[GESTURE_DOUBLE],
                 sb.seen[GESTURE_HOLD], sb.seen[GESTURE_NONE]);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Far beyond the slowest correct run, including every stall.
    initial begin
        #200000;
        $display("Timed out with %0d gestures still owed.", sb.expected_q.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
